// ===== src/ueu_pkg.sv =====
// shared types, character constants and hex helper functions for the escape converter
// no dependencies; imported by every module of the block
package ueu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam int         LIT_MAX   = 6;
    localparam int         UTF_MAX   = 3;

    // one queued output job: a run of literal bytes or an encoded code point
    typedef struct packed {
        logic                      enc;
        logic [3:0]                cnt;
        logic [LIT_MAX-1:0][7:0]   lit;
        logic [UTF_MAX-1:0][7:0]   utf;
    } ueu_cmd_t;

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46))
            || ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if ((b >= 8'h30) && (b <= 8'h39))
            v = b - 8'h30;
        else if ((b >= 8'h41) && (b <= 8'h46))
            v = b - 8'h37;
        else if ((b >= 8'h61) && (b <= 8'h66))
            v = b - 8'h57;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

endpackage

// ===== src/unicode_escape_to_utf8_hex.sv =====
// Converts \uXXXX escapes in a text byte stream into \xHH UTF-8 byte escapes.
// Input channel in_valid/in_stall carries in_byte and in_last, one word per item.
// Output channel out_valid/out_stall carries out_byte and out_last; out_last marks
// the final word caused by one input word. Words held as a partial escape give no
// output until the escape completes or fails; in_last flushes anything held.
// An output word passes through the job queue and then the output register.
// Throughput: one input word per cycle while the job queue has room; the output side
// emits one word per cycle while out_stall is low, so an escape drains as 4, 8 or
// 12 words and a failed match as up to 6. The queue of FIFO_DEPTH jobs lets the
// input keep running while such a burst drains.
// Reset: no partial escape held, queue empty, out_valid low.
// When out_stall is high the output register holds its word; the queue then fills
// and in_stall rises once it is full.
// depends on ueu_pkg, ueu_front, ueu_queue, ueu_back
module unicode_escape_to_utf8_hex
    import ueu_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic     accept;
    logic     push;
    ueu_cmd_t push_cmd;
    ueu_cmd_t head_cmd;
    logic     pop;
    logic     full;
    logic     empty;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    ueu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ueu_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    ueu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ===== src/ueu_front.sv =====
// front end: accepts source words, tracks a partial escape and builds at most one output job per word
// depends on ueu_pkg
module ueu_front
    import ueu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output ueu_cmd_t   push_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_BS   = 3'd1,
        ST_U    = 3'd2,
        ST_D1   = 3'd3,
        ST_D2   = 3'd4,
        ST_D3   = 3'd5
    } stage_t;

    stage_t          stage_reg;
    stage_t          stage_next;
    logic [2:0][7:0] digit_reg;
    logic            digit_we;
    logic [1:0]      digit_idx;
    logic [2:0]      held_len;
    logic [2:0]      lit_len;
    logic [3:0]      lit_cnt;
    logic            do_enc;
    logic [4:0][7:0] held;
    logic [15:0]     cp;

    assign held      = {digit_reg[2], digit_reg[1], digit_reg[0], CH_U, CH_BSLASH};
    assign digit_idx = 2'(stage_reg - ST_U);
    assign cp        = {hex_val(digit_reg[0]), hex_val(digit_reg[1]),
                        hex_val(digit_reg[2]), hex_val(in_byte)};

    always_comb
    begin
        case (stage_reg)
            ST_BS, ST_U, ST_D1, ST_D2, ST_D3: held_len = stage_reg;
            default:                          held_len = 3'd0;
        endcase
    end

    always_comb
    begin
        stage_next = stage_reg;
        digit_we   = 1'b0;
        push       = 1'b0;
        do_enc     = 1'b0;
        lit_len    = held_len;
        lit_cnt    = 4'd0;
        if (accept)
        begin
            if ((stage_reg == ST_BS) && (in_byte == CH_U))
            begin
                if (in_last)
                begin
                    push       = 1'b1;
                    lit_len    = 3'd1;
                    lit_cnt    = 4'd2;
                    stage_next = ST_IDLE;
                end
                else
                begin
                    stage_next = ST_U;
                end
            end
            else if ((stage_reg >= ST_U) && (stage_reg <= ST_D3) && is_hex(in_byte))
            begin
                if (stage_reg == ST_D3)
                begin
                    push       = 1'b1;
                    do_enc     = 1'b1;
                    stage_next = ST_IDLE;
                end
                else
                begin
                    digit_we = 1'b1;
                    if (in_last)
                    begin
                        // held prefix plus this digit
                        push       = 1'b1;
                        lit_len    = stage_reg;
                        lit_cnt    = {1'b0, stage_reg} + 4'd1;
                        stage_next = ST_IDLE;
                    end
                    else
                    begin
                        stage_next = stage_t'(stage_reg + 3'd1);
                    end
                end
            end
            else
            begin
                // failed match or idle: pass held bytes, then rescan this word
                lit_len = held_len;
                if ((in_byte == CH_BSLASH) && !in_last)
                begin
                    lit_cnt    = {1'b0, held_len};
                    push       = (held_len != 3'd0);
                    stage_next = ST_BS;
                end
                else
                begin
                    lit_cnt    = {1'b0, held_len} + 4'd1;
                    push       = 1'b1;
                    stage_next = ST_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        push_cmd     = '0;
        push_cmd.enc = do_enc;
        for (int i = 0; i < LIT_MAX - 1; i++)
        begin
            push_cmd.lit[i] = (3'(i) < lit_len) ? held[i] : in_byte;
        end
        // the last slot only ever carries the word itself
        push_cmd.lit[LIT_MAX-1] = in_byte;
        if (do_enc)
        begin
            if (cp[15:7] == 9'd0)
            begin
                push_cmd.cnt    = 4'd4;
                push_cmd.utf[0] = cp[7:0];
            end
            else if (cp[15:11] == 5'd0)
            begin
                push_cmd.cnt    = 4'd8;
                push_cmd.utf[0] = 8'hC0 | {3'b000, cp[10:6]};
                push_cmd.utf[1] = 8'h80 | {2'b00, cp[5:0]};
            end
            else
            begin
                push_cmd.cnt    = 4'd12;
                push_cmd.utf[0] = 8'hE0 | {4'h0, cp[15:12]};
                push_cmd.utf[1] = 8'h80 | {2'b00, cp[11:6]};
                push_cmd.utf[2] = 8'h80 | {2'b00, cp[5:0]};
            end
        end
        else
        begin
            push_cmd.cnt = lit_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digit_reg[digit_idx] <= in_byte;
        end
    end

endmodule

// ===== src/ueu_queue.sv =====
// short job queue between front and back ends, register based
// depends on ueu_pkg
module ueu_queue
    import ueu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ueu_cmd_t push_cmd,
    input  logic     pop,
    output ueu_cmd_t head_cmd,
    output logic     full,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ueu_cmd_t          mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a word");

endmodule

// ===== src/ueu_back.sv =====
// back end: expands queued jobs into output words through an output register
// depends on ueu_pkg
module ueu_back
    import ueu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ueu_cmd_t   head_cmd,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       cmd_done;
    logic [7:0] sel_byte;
    logic [7:0] utf_sel;

    assign load     = !out_valid_reg || !out_stall;
    assign cmd_done = (idx_reg == head_cmd.cnt - 4'd1);
    assign pop      = load && !empty && cmd_done;

    always_comb
    begin
        case (idx_reg[3:2])
            2'd0:    utf_sel = head_cmd.utf[0];
            2'd1:    utf_sel = head_cmd.utf[1];
            2'd2:    utf_sel = head_cmd.utf[2];
            default: utf_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        if (head_cmd.enc)
        begin
            // each utf-8 byte becomes backslash, x, two hex digits
            case (idx_reg[1:0])
                2'd0:    sel_byte = CH_BSLASH;
                2'd1:    sel_byte = CH_X;
                2'd2:    sel_byte = hex_char(utf_sel[7:4]);
                default: sel_byte = hex_char(utf_sel[3:0]);
            endcase
        end
        else
        begin
            case (idx_reg[2:0])
                3'd0:    sel_byte = head_cmd.lit[0];
                3'd1:    sel_byte = head_cmd.lit[1];
                3'd2:    sel_byte = head_cmd.lit[2];
                3'd3:    sel_byte = head_cmd.lit[3];
                3'd4:    sel_byte = head_cmd.lit[4];
                3'd5:    sel_byte = head_cmd.lit[5];
                default: sel_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                idx_next = cmd_done ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            out_byte_reg <= sel_byte;
            out_last_reg <= cmd_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) empty |-> (idx_reg == 4'd0))
        else $error("job index moved with no job queued");
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> (idx_reg < head_cmd.cnt))
        else $error("job index beyond job length");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_cmd.enc) |-> (idx_reg[1:0] == 2'd3))
        else $error("encoded job ended inside a byte escape");

endmodule

// ===== dv/utf8_escape_checker.sv =====
// checker for the escape converter: predicts the output words of every accepted input
// word and compares each accepted output word, in order, against that prediction
// depends on ueu_pkg for the character constants
module utf8_escape_checker
    import ueu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    output int         mismatches,
    output int         outstanding,
    output int         checked
);

    typedef enum logic [2:0]
    {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_U,
        SCAN_D1,
        SCAN_D2,
        SCAN_D3
    } scan_stage_e;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    scan_stage_e scan_stage = SCAN_IDLE;
    logic [7:0]  held_hex [4];
    logic [7:0]  burst [$];
    text_word_t  awaited_words [$];
    int          miss_cnt = 0;
    int          word_cnt = 0;

    function automatic logic hex_digit(input logic [7:0] b);
        return ((b >= "0") && (b <= "9")) || ((b >= "A") && (b <= "F"))
            || ((b >= "a") && (b <= "f"));
    endfunction

    // only called on bytes already known to be hex digits
    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [7:0] v;
        if (b <= "9")
            v = b - "0";
        else
            v = (b | 8'h20) - "a" + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_text(input logic [3:0] n);
        logic [7:0] v;
        if (n < 4'd10)
            v = "0" + n;
        else
            v = "a" + n - 8'd10;
        return v;
    endfunction

    task automatic push_escaped(input logic [7:0] b);
        burst.push_back(CH_BSLASH);
        burst.push_back(CH_X);
        burst.push_back(hex_text(b[7:4]));
        burst.push_back(hex_text(b[3:0]));
    endtask

    // pass out whatever part of an escape is held, then drop back to idle
    task automatic release_held();
        int i;
        if (scan_stage != SCAN_IDLE)
        begin
            burst.push_back(CH_BSLASH);
            if (scan_stage >= SCAN_U)
            begin
                burst.push_back(CH_U);
                for (i = 0; i < int'(scan_stage) - int'(SCAN_U); i++)
                    burst.push_back(held_hex[i]);
            end
        end
        scan_stage = SCAN_IDLE;
    endtask

    task automatic encode_point();
        logic [15:0] cp;
        cp = {nibble_of(held_hex[0]), nibble_of(held_hex[1]),
              nibble_of(held_hex[2]), nibble_of(held_hex[3])};
        if (cp < 16'h0080)
            push_escaped(cp[7:0]);
        else if (cp < 16'h0800)
        begin
            push_escaped({3'b110, cp[10:6]});
            push_escaped({2'b10, cp[5:0]});
        end
        else
        begin
            push_escaped({4'b1110, cp[15:12]});
            push_escaped({2'b10, cp[11:6]});
            push_escaped({2'b10, cp[5:0]});
        end
    endtask

    task automatic predict_word(input logic [7:0] b, input logic last);
        text_word_t w;
        int         i;
        burst.delete();
        if ((scan_stage == SCAN_SLASH) && (b == CH_U))
            scan_stage = SCAN_U;
        else if ((scan_stage >= SCAN_U) && hex_digit(b))
        begin
            held_hex[int'(scan_stage) - int'(SCAN_U)] = b;
            if (scan_stage == SCAN_D3)
            begin
                encode_point();
                scan_stage = SCAN_IDLE;
            end
            else
                scan_stage = scan_stage_e'(scan_stage + 3'd1);
        end
        else
        begin
            // failed match: held bytes go out, then this byte is scanned from idle
            release_held();
            if (b == CH_BSLASH)
                scan_stage = SCAN_SLASH;
            else
                burst.push_back(b);
        end
        if (last)
            release_held();
        for (i = 0; i < burst.size(); i++)
        begin
            w.data = burst[i];
            w.last = (i == burst.size() - 1);
            awaited_words.push_back(w);
        end
    endtask

    task automatic note_miss(input string msg);
        if (miss_cnt < 10)
            $display("%s", msg);
        miss_cnt++;
    endtask

    always @(posedge clk)
    begin
        text_word_t want;
        if (rst_n)
        begin
            // output first: a word cannot come out at the edge that accepts its cause
            if (out_valid && !out_stall)
            begin
                word_cnt++;
                if (awaited_words.size() == 0)
                    note_miss($sformatf("unexpected output word %02h last %0b",
                                        out_byte, out_last));
                else
                begin
                    want = awaited_words.pop_front();
                    if ((out_byte !== want.data) || (out_last !== want.last))
                        note_miss($sformatf(
                            "output word %0d: expected %02h last %0b, got %02h last %0b",
                            word_cnt, want.data, want.last, out_byte, out_last));
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_byte, in_last);
        end
        mismatches  <= miss_cnt;
        outstanding <= awaited_words.size();
        checked     <= word_cnt;
    end

endmodule

// ===== dv/tb_top.sv =====
// top of the escape converter testbench: clock, reset, stimulus, output stalls and verdict
// depends on ueu_pkg, unicode_escape_to_utf8_hex and utf8_escape_checker
module tb_top
    import ueu_pkg::*;
;

    localparam int IDLE_LIMIT   = 500;
    localparam int RANDOM_WORDS = 375;
    localparam int TAIL_CYCLES  = 24;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;

    int mismatches;
    int outstanding;
    int checked;

    bit no_idle      = 1'b0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int words_sent   = 0;
    int escapes_sent = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    unicode_escape_to_utf8_hex DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    utf8_escape_checker CHK
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // after each accepted output word, stall for a drawn number of cycles
    always @(posedge clk)
    begin
        int w;
        if (rst_n && out_valid && !out_stall)
        begin
            w = no_idle ? 0 : int'($urandom_range(0, 11));
            stall_left <= w;
            out_stall  <= (w != 0);
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles == IDLE_LIMIT - 1)
            begin
                $display("no word moved for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 11));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_escape(input logic [15:0] cp, input logic last);
        logic [3:0] n;
        logic [7:0] ch;
        int         i;
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        for (i = 3; i >= 0; i--)
        begin
            n = cp[i*4 +: 4];
            if (n < 4'd10)
                ch = "0" + n;
            else if ($urandom_range(0, 1))
                ch = "A" + n - 8'd10;
            else
                ch = "a" + n - 8'd10;
            send_word(ch, (i == 0) && last);
        end
        escapes_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          kind;
        int          held;
        int          j;
        int          k;
        int          start_mark;
        bit          paused;
        bit          cut;
        logic [15:0] cp;
        logic [7:0]  part [$];

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_escape(16'h007F, 1'b0);
        send_escape(16'hFFFF, 1'b0);
        // backslash not followed by u
        send_word(CH_BSLASH, 1'b0);
        send_word("Z", 1'b0);
        // second backslash restarts the match, which then fails on a non-hex digit
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word("0", 1'b0);
        send_word("8", 1'b0);
        send_word("g", 1'b0);
        // stream end while an escape is half held
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word("a", 1'b1);

        hold_until_drained();

        start_mark = words_sent;
        paused = 1'b0;
        while (words_sent < start_mark + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle <= ~no_idle;
            if (!paused && (words_sent >= start_mark + RANDOM_WORDS / 2))
            begin
                hold_until_drained();
                paused = 1'b1;
            end
            kind = int'($urandom_range(0, 9));
            if (kind <= 5)
            begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default:
                        case ($urandom_range(0, 5))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            default: cp = 16'hFFFF;
                        endcase
                endcase
                send_escape(cp, $urandom_range(0, 19) == 0);
            end
            else if (kind == 6)
            begin
                // broken escape: a held prefix, then a byte that may or may not break it, or the stream end
                held = int'($urandom_range(0, 4));
                part.delete();
                part.push_back(CH_BSLASH);
                if (held > 0)
                    part.push_back(CH_U);
                for (j = 1; j < held; j++)
                begin
                    k = int'($urandom_range(0, 21));
                    if (k < 10)
                        part.push_back(8'("0" + k));
                    else if (k < 16)
                        part.push_back(8'("a" + k - 10));
                    else
                        part.push_back(8'("A" + k - 16));
                end
                cut = ($urandom_range(0, 3) == 0);
                for (j = 0; j < part.size(); j++)
                    send_word(part[j], cut && (j == part.size() - 1));
                if (!cut)
                    case ($urandom_range(0, 2))
                        0: send_word(CH_BSLASH, 1'b0);
                        1: send_word(8'($urandom_range(0, 255)), 1'b0);
                        default: send_word(CH_U, 1'b0);
                    endcase
            end
            else
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d input words with %0d complete escapes among them",
                 words_sent, escapes_sent);
        $display("%0d output words compared against the predicted text", checked);
        if ((mismatches == 0) && (outstanding == 0))
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ueu_pkg.sv
src/ueu_front.sv
src/ueu_queue.sv
src/ueu_back.sv
src/unicode_escape_to_utf8_hex.sv
dv/utf8_escape_checker.sv
dv/tb_top.sv
